// ===== hw/rtl/unix_seconds_to_utc_date_time_assert.svh =====
// Assertion macros for the Unix seconds to UTC date and time converter.
// Expects signals named clk and arst_n in the including module.
`ifndef UNIX_SECONDS_TO_UTC_DATE_TIME_ASSERT_SVH
`define UNIX_SECONDS_TO_UTC_DATE_TIME_ASSERT_SVH

// check a consequent in the same cycle as its antecedent: same-cycle implication
`define UTCDT_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a property of every presented result item
`define UTCDT_ASSERT_ON_OUT(label, cons, msg) \
	`UTCDT_ASSERT_IMPLIES(label, out_valid, cons, msg)

`endif

// ===== hw/rtl/utcdt_pkg.sv =====
// Package for the Unix seconds to UTC date and time converter.
// Field widths, reciprocal constants for the constant divisions, month table.
// No dependencies.
package utcdt_pkg;

	localparam int SECS_W  = 39;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;

	localparam int NUM_STAGES = 12;

	localparam int DAYS_W = 22;
	localparam int SOD_W  = 17;
	localparam int TM_W   = 11;
	localparam int ERA_W  = 5;
	localparam int DOE_W  = 18;
	localparam int YOE_W  = 9;
	localparam int DOY_W  = 9;
	localparam int MP_W   = 4;

	localparam logic signed [SECS_W-1:0] SECS_MIN  = -39'sd62135596800;
	localparam logic signed [SECS_W-1:0] SECS_MAX  = 39'sd253402300799;
	localparam logic [SECS_W-1:0]        SECS_BIAS = 39'd62135596800;

	// 86400 = 675 << 7
	localparam int         DAY_SHIFT = 7;
	localparam logic [9:0] DAY_ODD   = 10'd675;
	localparam int         K_675     = 41;
	localparam logic [31:0] RECIP_675 =
		32'(((64'd1 << K_675) + 64'd674) / 64'd675);

	localparam logic [DAYS_W-1:0] Z_OFFSET     = 22'd306;
	localparam logic [DOE_W-1:0]  DAYS_PER_ERA = 18'd146097;
	localparam logic [DOE_W-1:0]  DOE_LAST     = 18'd146096;
	localparam int                K_ERA        = 39;
	localparam logic [21:0] RECIP_ERA =
		22'(((64'd1 << K_ERA) + 64'd146096) / 64'd146097);

	localparam logic [5:0] SIXTY = 6'd60;
	localparam int         K_MIN = 23;
	localparam logic [17:0] RECIP_60_SOD =
		18'(((64'd1 << K_MIN) + 64'd59) / 64'd60);
	localparam int         K_HOUR = 17;
	localparam logic [11:0] RECIP_60_TM =
		12'(((64'd1 << K_HOUR) + 64'd59) / 64'd60);

	localparam int K_1460 = 28;
	localparam logic [17:0] RECIP_1460 =
		18'(((64'd1 << K_1460) + 64'd1459) / 64'd1460);
	localparam int K_36524 = 33;
	localparam logic [17:0] RECIP_36524 =
		18'(((64'd1 << K_36524) + 64'd36523) / 64'd36524);
	localparam int K_365 = 26;
	localparam logic [17:0] RECIP_365 =
		18'(((64'd1 << K_365) + 64'd364) / 64'd365);
	localparam int K_100 = 16;
	localparam logic [9:0] RECIP_100 =
		10'(((64'd1 << K_100) + 64'd99) / 64'd100);
	localparam int K_153 = 19;
	localparam logic [11:0] RECIP_153 =
		12'(((64'd1 << K_153) + 64'd152) / 64'd153);
	// (5 * doy + 2) * RECIP_153 folded into one constant product
	localparam logic [14:0] MP_MUL = 15'(5 * RECIP_153);
	localparam logic [12:0] MP_ADD = 13'(2 * RECIP_153);

	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [8:0] YEARS_PER_ERA = 9'd400;
	localparam logic [MP_W-1:0] MP_JANUARY = 4'd10;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} hms_t;

	// first day of each March-based month within the year
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] res;
		unique case (mp)
			4'd0:    res = 9'd0;
			4'd1:    res = 9'd31;
			4'd2:    res = 9'd61;
			4'd3:    res = 9'd92;
			4'd4:    res = 9'd122;
			4'd5:    res = 9'd153;
			4'd6:    res = 9'd184;
			4'd7:    res = 9'd214;
			4'd8:    res = 9'd245;
			4'd9:    res = 9'd275;
			4'd10:   res = 9'd306;
			4'd11:   res = 9'd337;
			default: res = 9'd0;
		endcase
		return res;
	endfunction

endpackage

// ===== hw/rtl/unix_seconds_to_utc_date_time.sv =====
// Unix seconds to UTC date and time converter, top level.
// Depends on utcdt_pkg and unix_seconds_to_utc_date_time_assert.svh.
// Twelve-stage pipeline, divisions by constants done by reciprocal multiplies, shifts and one compare.

// Takes one signed seconds count per cycle while in_ready is high and gives
// year, month, day, hour, minute and second through the twelve pipeline
// register stages, which hold the reciprocal multiplies, the subtractions and
// the compares. Inputs outside 0001-01-01T00:00:00Z to 9999-12-31T23:59:59Z
// are clamped to those ends. Any empty stage fills while the output waits, so
// in_ready stays high until all twelve stages hold items.
`include "unix_seconds_to_utc_date_time_assert.svh"

module unix_seconds_to_utc_date_time (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [utcdt_pkg::SECS_W-1:0] unix_seconds,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [utcdt_pkg::YEAR_W-1:0]        year,
	output logic [utcdt_pkg::MONTH_W-1:0]       month,
	output logic [utcdt_pkg::DAY_W-1:0]         day,
	output logic [utcdt_pkg::HOUR_W-1:0]        hour,
	output logic [utcdt_pkg::MIN_W-1:0]         minute,
	output logic [utcdt_pkg::SEC_W-1:0]         second
);
	import utcdt_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] adv;

	logic signed [SECS_W-1:0] sat;
	logic [SECS_W-1:0]        xs_s1;
	logic [63:0]              prod_675;
	logic [31:0]              x_s2;
	logic [DAY_SHIFT-1:0]     lo_s2;
	logic [DAYS_W-1:0]        q_s2;
	logic [31:0]              rem_675;
	logic [DAYS_W-1:0]        z_s3, z_s4;
	logic [SOD_W-1:0]         sod_s3, sod_s4;
	logic [43:0]              prod_era;
	logic [34:0]              prod_tm;
	logic [ERA_W-1:0]         era_s4, era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [TM_W-1:0]          tm_s4, tm_s5;
	logic [DAYS_W-1:0]        doe_full;
	logic [SOD_W-1:0]         sec_full;
	logic [22:0]              prod_hour;
	logic [DOE_W-1:0]         doe_s5, doe_s6, doe_s7, doe_s8, doe_s9;
	logic [HOUR_W-1:0]        hour_s5;
	logic [SEC_W-1:0]         second_s5;
	logic [TM_W-1:0]          min_full;
	logic [35:0]              prod_1460, prod_36524;
	logic [6:0]               c1460_s6;
	logic [2:0]               c36524_s6;
	logic                     clast_s6;
	hms_t                     hms_s6, hms_s7, hms_s8, hms_s9, hms_s10, hms_s11, hms_s12;
	logic [DOE_W-1:0]         n_s7;
	logic [35:0]              prod_365;
	logic [YOE_W-1:0]         yoe_s8, yoe_s9, yoe_s10;
	logic [18:0]              prod_100;
	logic [DOE_W-1:0]         base_s9;
	logic [1:0]               c100_s9;
	logic [DOE_W-1:0]         doy_full;
	logic [DOY_W-1:0]         doy_s10, doy_s11;
	logic [23:0]              prod_mp;
	logic [MP_W-1:0]          mp_s11;
	logic [YEAR_W-1:0]        ybase_s11;
	logic [DOY_W-1:0]         day_full;
	logic [MONTH_W-1:0]       month_d;
	logic [YEAR_W-1:0]        year_s12;
	logic [MONTH_W-1:0]       month_s12;
	logic [DAY_W-1:0]         day_s12;

	// advance a stage when it is empty or its successor advances
	always_comb begin
		adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// clamp and bias to seconds since 0001-01-01
	always_comb begin
		priority if (unix_seconds < SECS_MIN) begin
			sat = SECS_MIN;
		end else if (unix_seconds > SECS_MAX) begin
			sat = SECS_MAX;
		end else begin
			sat = unix_seconds;
		end
	end

	assign prod_675  = 64'(xs_s1[SECS_W-1:DAY_SHIFT]) * 64'(RECIP_675);
	assign rem_675   = x_s2 - 32'(q_s2) * 32'(DAY_ODD);
	assign prod_era  = 44'(z_s3) * 44'(RECIP_ERA);
	assign prod_tm   = 35'(sod_s3) * 35'(RECIP_60_SOD);
	assign doe_full  = z_s4 - 22'(era_s4) * 22'(DAYS_PER_ERA);
	assign sec_full  = sod_s4 - 17'(tm_s4) * 17'(SIXTY);
	assign prod_hour = 23'(tm_s4) * 23'(RECIP_60_TM);
	assign min_full  = tm_s5 - 11'(hour_s5) * 11'(SIXTY);
	assign prod_1460  = 36'(doe_s5) * 36'(RECIP_1460);
	assign prod_36524 = 36'(doe_s5) * 36'(RECIP_36524);
	assign prod_365  = 36'(n_s7) * 36'(RECIP_365);
	assign prod_100  = 19'(yoe_s8) * 19'(RECIP_100);
	assign doy_full  = doe_s9 - (base_s9 + 18'(yoe_s9[YOE_W-1:2]) - 18'(c100_s9));
	assign prod_mp   = 24'(doy_s10) * 24'(MP_MUL) + 24'(MP_ADD);
	assign day_full  = doy_s11 - month_start(mp_s11) + 9'd1;
	assign month_d   = (mp_s11 < MP_JANUARY) ? 4'(mp_s11 + 4'd3) : 4'(mp_s11 - 4'd9);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			xs_s1 <= SECS_W'(sat) + SECS_BIAS;
		end
		if (adv[1]) begin
			x_s2  <= xs_s1[SECS_W-1:DAY_SHIFT];
			lo_s2 <= xs_s1[DAY_SHIFT-1:0];
			q_s2  <= prod_675[K_675 +: DAYS_W];
		end
		if (adv[2]) begin
			z_s3   <= q_s2 + Z_OFFSET;
			sod_s3 <= {rem_675[9:0], lo_s2};
		end
		if (adv[3]) begin
			z_s4   <= z_s3;
			sod_s4 <= sod_s3;
			era_s4 <= prod_era[K_ERA +: ERA_W];
			tm_s4  <= prod_tm[K_MIN +: TM_W];
		end
		if (adv[4]) begin
			doe_s5    <= doe_full[DOE_W-1:0];
			era_s5    <= era_s4;
			tm_s5     <= tm_s4;
			hour_s5   <= prod_hour[K_HOUR +: HOUR_W];
			second_s5 <= sec_full[SEC_W-1:0];
		end
		if (adv[5]) begin
			doe_s6           <= doe_s5;
			era_s6           <= era_s5;
			c1460_s6         <= prod_1460[K_1460 +: 7];
			c36524_s6        <= prod_36524[K_36524 +: 3];
			clast_s6         <= (doe_s5 == DOE_LAST);
			hms_s6.hour      <= hour_s5;
			hms_s6.minute    <= min_full[MIN_W-1:0];
			hms_s6.second    <= second_s5;
		end
		if (adv[6]) begin
			n_s7   <= doe_s6 - 18'(c1460_s6) + 18'(c36524_s6) - 18'(clast_s6);
			doe_s7 <= doe_s6;
			era_s7 <= era_s6;
			hms_s7 <= hms_s6;
		end
		if (adv[7]) begin
			yoe_s8 <= prod_365[K_365 +: YOE_W];
			doe_s8 <= doe_s7;
			era_s8 <= era_s7;
			hms_s8 <= hms_s7;
		end
		if (adv[8]) begin
			base_s9 <= 18'(yoe_s8) * 18'(DAYS_PER_YEAR);
			c100_s9 <= prod_100[K_100 +: 2];
			yoe_s9  <= yoe_s8;
			doe_s9  <= doe_s8;
			era_s9  <= era_s8;
			hms_s9  <= hms_s8;
		end
		if (adv[9]) begin
			doy_s10 <= doy_full[DOY_W-1:0];
			yoe_s10 <= yoe_s9;
			era_s10 <= era_s9;
			hms_s10 <= hms_s9;
		end
		if (adv[10]) begin
			mp_s11    <= prod_mp[K_153 +: MP_W];
			doy_s11   <= doy_s10;
			ybase_s11 <= 14'(era_s10) * 14'(YEARS_PER_ERA) + 14'(yoe_s10);
			hms_s11   <= hms_s10;
		end
		if (adv[11]) begin
			year_s12  <= ybase_s11 + 14'(month_d <= MONTH_FEB);
			month_s12 <= month_d;
			day_s12   <= day_full[DAY_W-1:0];
			hms_s12   <= hms_s11;
		end
	end

	assign out_valid = vld_q[NUM_STAGES-1];
	assign year      = year_s12;
	assign month     = month_s12;
	assign day       = day_s12;
	assign hour      = hms_s12.hour;
	assign minute    = hms_s12.minute;
	assign second    = hms_s12.second;

	`UTCDT_ASSERT_IMPLIES(a_ready_flow, out_ready, in_ready, "input stalled while output drains")
	`UTCDT_ASSERT_ON_OUT(a_date_range, year >= 14'd1 && year <= 14'd9999 && month >= 4'd1 && month <= 4'd12 && day >= 5'd1, "date field out of range")
	`UTCDT_ASSERT_ON_OUT(a_time_range, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59, "time field out of range")
	`UTCDT_ASSERT_ON_OUT(a_month_len, (month != 4'd2 || day <= 5'd29) && ((month != 4'd4 && month != 4'd6 && month != 4'd9 && month != 4'd11) || day <= 5'd30), "day past end of month")

endmodule

// ===== tb/utc_date_time_checker.sv =====
// Checker for the Unix seconds to UTC date and time converter: watches both channels,
// predicts each calendar result from the accepted seconds count and compares field by field.
// Depends on utcdt_pkg for the field widths and the clamp limits.
module utc_date_time_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [utcdt_pkg::SECS_W-1:0] unix_seconds,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [utcdt_pkg::YEAR_W-1:0]        year,
	input  logic [utcdt_pkg::MONTH_W-1:0]       month,
	input  logic [utcdt_pkg::DAY_W-1:0]         day,
	input  logic [utcdt_pkg::HOUR_W-1:0]        hour,
	input  logic [utcdt_pkg::MIN_W-1:0]         minute,
	input  logic [utcdt_pkg::SEC_W-1:0]         second,
	output int                                  mismatches,
	output int                                  dates_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import utcdt_pkg::*;

	localparam longint SECS_PER_DAY  = 86400;
	localparam longint SECS_PER_HOUR = 3600;
	localparam longint EPOCH_SHIFT   = 719468;
	localparam longint ERA_DAYS      = 146097;
	localparam int     MAX_LINES     = 40;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} date_time_t;

	date_time_t expected_dates[$];
	int         taken_count = 0;
	int         given_count = 0;

	initial mismatches = 0;
	assign dates_pending = taken_count - given_count;

	function automatic longint div_down(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && (num % den) < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic date_time_t civil_from_seconds(input logic signed [SECS_W-1:0] raw);
		longint     s, days, sod, z, era, doe, yoe, doy, mp, d, m, y;
		date_time_t r;
		s = raw;
		if (s < longint'(SECS_MIN))
			s = longint'(SECS_MIN);
		if (s > longint'(SECS_MAX))
			s = longint'(SECS_MAX);
		days = div_down(s, SECS_PER_DAY);
		sod  = s - days * SECS_PER_DAY;
		z    = days + EPOCH_SHIFT;
		era  = div_down(z, ERA_DAYS);
		doe  = z - era * ERA_DAYS;
		yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		y    = yoe + era * 400;
		doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp   = (5 * doy + 2) / 153;
		d    = doy - (153 * mp + 2) / 5 + 1;
		m    = (mp < 10) ? mp + 3 : mp - 9;
		if (m <= 2)
			y = y + 1;
		r.year   = y[YEAR_W-1:0];
		r.month  = m[MONTH_W-1:0];
		r.day    = d[DAY_W-1:0];
		r.hour   = 5'(sod / SECS_PER_HOUR);
		r.minute = 6'((sod % SECS_PER_HOUR) / 60);
		r.second = 6'(sod % 60);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_LINES)
			$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches = mismatches + 1;
	endtask

	always @(posedge clk) begin
		date_time_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_dates.push_back(civil_from_seconds(unix_seconds));
				taken_count <= taken_count + 1;
			end
			if (out_valid && out_ready) begin
				given_count <= given_count + 1;
				if (expected_dates.size() == 0) begin
					report_mismatch("unexpected item", 1, 0);
				end else begin
					want = expected_dates.pop_front();
					if (year !== want.year)
						report_mismatch("year", year, want.year);
					if (month !== want.month)
						report_mismatch("month", month, want.month);
					if (day !== want.day)
						report_mismatch("day", day, want.day);
					if (hour !== want.hour)
						report_mismatch("hour", hour, want.hour);
					if (minute !== want.minute)
						report_mismatch("minute", minute, want.minute);
					if (second !== want.second)
						report_mismatch("second", second, want.second);
				end
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for unix_seconds_to_utc_date_time: clock, reset, seconds-count
// stimulus with random idling on both channels, and the verdict.
// Depends on utcdt_pkg, the converter RTL and utc_date_time_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import utcdt_pkg::*;

	localparam int     RANDOM_ITEMS = 1150;
	localparam int     CYCLE_LIMIT  = 200000;
	localparam int     DRAIN_CYCLES = 3 * NUM_STAGES;
	localparam longint DAY_SECS     = 86400;
	localparam int     LAST_DAY     = 3652058;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [SECS_W-1:0] unix_seconds = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [YEAR_W-1:0]        year;
	logic [MONTH_W-1:0]       month;
	logic [DAY_W-1:0]         day;
	logic [HOUR_W-1:0]        hour;
	logic [MIN_W-1:0]         minute;
	logic [SEC_W-1:0]         second;
	logic                     calm = 1'b0;
	int                       mismatches;
	int                       dates_pending;
	int                       cycles = 0;

	longint directed_seconds[$] = '{
		longint'(SECS_MIN), longint'(SECS_MAX), longint'(SECS_MIN) - 1,
		longint'(SECS_MAX) + 1, -(64'sd1 <<< 38), (64'sd1 <<< 38) - 1,
		0, -1, 1, 86399, 86400, -86400, -86401,
		951782400, 951868799, 951868800, 4107456000, 4107542400,
		-2208988800, -11644473600, 253402214400, -62135510401,
		64'sh55_5555_5555, -64'sh2A_AAAA_AAAB
	};

	unix_seconds_to_utc_date_time dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.unix_seconds(unix_seconds),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.year        (year),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second)
	);

	utc_date_time_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.unix_seconds (unix_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.mismatches   (mismatches),
		.dates_pending(dates_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 20);
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_seconds(input longint v);
		if (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		unix_seconds <= SECS_W'(v);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_dates();
		in_valid <= 1'b0;
		@(posedge clk);
		while (dates_pending != 0) @(posedge clk);
	endtask

	function automatic longint random_seconds();
		longint unsigned r;
		longint          span;
		int              pick;
		r    = {$urandom, $urandom};
		span = longint'(SECS_MAX) - longint'(SECS_MIN) + 1;
		pick = $urandom_range(99);
		if (pick < 65)
			return longint'(SECS_MIN) + longint'(r % span);
		else if (pick < 77)
			return longint'(SECS_W'(r)) - ((r >> (SECS_W - 1)) & 1 ? 64'sd1 <<< SECS_W : 0);
		else if (pick < 90)
			return longint'(SECS_MIN) + longint'($urandom_range(0, LAST_DAY)) * DAY_SECS
				+ longint'($urandom_range(0, 4)) - 2;
		else if (pick < 95)
			return longint'(SECS_MIN) + longint'($urandom_range(0, 2000)) - 1000;
		else
			return longint'(SECS_MAX) + longint'($urandom_range(0, 2000)) - 1000;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_seconds[i])
			push_seconds(directed_seconds[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				drain_dates();
			if (n == 500)
				calm <= 1'b1;
			if (n == 700)
				calm <= 1'b0;
			push_seconds(random_seconds());
		end
		drain_dates();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && dates_pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/utcdt_pkg.sv
hw/rtl/unix_seconds_to_utc_date_time.sv
tb/utc_date_time_checker.sv
tb/testbench.sv
